FILE: src/tlac_pkg.sv
// ----------------------------------------------------------------------------
// tlac_pkg
// Types, constants and register codes shared by the three-layer alpha
// compositor.
// ----------------------------------------------------------------------------
package tlac_pkg;

   localparam int NumLayers = 3;
   localparam int NumLanes  = 3;
   localparam int LaneDepth = 2 * NumLayers;

   localparam logic [15:0] FullWeight = 16'd65025;
   localparam logic [7:0]  AlphaMax   = 8'd255;

   localparam int RecipShift = 40;
   localparam longint unsigned RecipWide =
      ((64'd1 << RecipShift) + 64'd65024) / 64'd65025;
   localparam logic [24:0] Recip = 25'(RecipWide);

   localparam logic [7:0] OpacityReset = 8'd255;

   typedef enum logic [1:0] {
      CSR_MASK_OPACITY    = 2'd0,
      CSR_BASE_VISIBLE    = 2'd1,
      CSR_MASK_VISIBLE    = 2'd2,
      CSR_OVERLAY_VISIBLE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] base_red;
      logic [7:0] base_green;
      logic [7:0] base_blue;
      logic [7:0] base_alpha;
      logic [7:0] mask_red;
      logic [7:0] mask_green;
      logic [7:0] mask_blue;
      logic [7:0] mask_alpha;
      logic [7:0] overlay_red;
      logic [7:0] overlay_green;
      logic [7:0] overlay_blue;
      logic [7:0] overlay_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic                                  valid;
      logic [NumLanes-1:0][NumLayers-1:0][7:0] src;
      logic [NumLayers-1:0][15:0]            weight;
      logic [7:0]                            alpha;
   } front_type;

endpackage

FILE: src/tlac_front.sv
// ----------------------------------------------------------------------------
// tlac_front
// Holds the configuration registers, takes one item per cycle unless busy and
// turns each layer's alpha into a blend weight and the saturated alpha sum.
// ----------------------------------------------------------------------------
module tlac_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tlac_pkg::req_type     req_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   output tlac_pkg::front_type   front
);

   logic       busy_ff;
   logic [7:0] opacity_ff, opacity_in;
   logic       base_vis_ff, base_vis_in;
   logic       mask_vis_ff, mask_vis_in;
   logic       over_vis_ff, over_vis_in;
   logic       accept;

   tlac_pkg::front_type front_ff, front_in;

   logic [15:0] base_w;
   logic [15:0] mask_w;
   logic [15:0] over_w;
   logic [9:0]  alpha_sum;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;
   assign front  = front_ff;

   always_comb begin
      opacity_in  = opacity_ff;
      base_vis_in = base_vis_ff;
      mask_vis_in = mask_vis_ff;
      over_vis_in = over_vis_ff;
      if (csr_we) begin
         unique case (tlac_pkg::csr_index_type'(csr_index))
            tlac_pkg::CSR_MASK_OPACITY:    opacity_in  = csr_wdata;
            tlac_pkg::CSR_BASE_VISIBLE:    base_vis_in = csr_wdata[0];
            tlac_pkg::CSR_MASK_VISIBLE:    mask_vis_in = csr_wdata[0];
            tlac_pkg::CSR_OVERLAY_VISIBLE: over_vis_in = csr_wdata[0];
            default:                       opacity_in  = opacity_ff;
         endcase
      end
   end

   always_comb begin
      base_w = base_vis_ff ?
               ({req_data.base_alpha, 8'd0} - {8'd0, req_data.base_alpha}) : 16'd0;
      mask_w = mask_vis_ff ? (req_data.mask_alpha * opacity_ff) : 16'd0;
      over_w = over_vis_ff ?
               ({req_data.overlay_alpha, 8'd0} - {8'd0, req_data.overlay_alpha}) : 16'd0;
      alpha_sum = (base_vis_ff ? {2'd0, req_data.base_alpha} : 10'd0)
                + (mask_vis_ff ? {2'd0, req_data.mask_alpha} : 10'd0)
                + (over_vis_ff ? {2'd0, req_data.overlay_alpha} : 10'd0);

      front_in.valid     = accept;
      front_in.src[0][0] = req_data.base_red;
      front_in.src[0][1] = req_data.mask_red;
      front_in.src[0][2] = req_data.overlay_red;
      front_in.src[1][0] = req_data.base_green;
      front_in.src[1][1] = req_data.mask_green;
      front_in.src[1][2] = req_data.overlay_green;
      front_in.src[2][0] = req_data.base_blue;
      front_in.src[2][1] = req_data.mask_blue;
      front_in.src[2][2] = req_data.overlay_blue;
      front_in.weight[0] = base_w;
      front_in.weight[1] = mask_w;
      front_in.weight[2] = over_w;
      front_in.alpha     = (alpha_sum > {2'd0, tlac_pkg::AlphaMax}) ?
                           tlac_pkg::AlphaMax : alpha_sum[7:0];
   end

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         opacity_ff     <= tlac_pkg::OpacityReset;
         base_vis_ff    <= 1'b1;
         mask_vis_ff    <= 1'b1;
         over_vis_ff    <= 1'b1;
         front_ff.valid <= 1'b0;
      end else begin
         opacity_ff     <= opacity_in;
         base_vis_ff    <= base_vis_in;
         mask_vis_ff    <= mask_vis_in;
         over_vis_ff    <= over_vis_in;
         front_ff.valid <= front_in.valid;
      end
      front_ff.src    <= front_in.src;
      front_ff.weight <= front_in.weight;
      front_ff.alpha  <= front_in.alpha;
   end

   // A hidden layer must not move the color.
   a_base_hidden: assert property (@(posedge clock) disable iff (reset)
      !base_vis_ff |=> front_ff.weight[0] == 16'd0)
      else $error("hidden base layer has a nonzero weight");

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> front_ff.valid)
      else $error("accepted item did not enter the lanes");

endmodule

FILE: src/tlac_lane.sv
// ----------------------------------------------------------------------------
// tlac_lane
// One color channel: blends the base, mask and overlay layers in turn, each
// layer taking a numerator stage and a reciprocal-scaling stage.
// ----------------------------------------------------------------------------
module tlac_lane (
   input  logic                                   clock,
   input  logic [tlac_pkg::NumLayers-1:0][7:0]    src,
   input  logic [tlac_pkg::NumLayers-1:0][15:0]   weight,
   output logic [7:0]                             color
);

   // Numerator src*w + dst*(65025-w), written as dst*65025 + (src-dst)*w.
   function automatic logic [23:0] blend_numer(input logic [7:0] s,
                                               input logic [7:0] d,
                                               input logic [15:0] w);
      logic signed [8:0]  diff;
      logic signed [16:0] ws;
      logic signed [25:0] prod;
      logic [23:0]        base;
      logic signed [26:0] total;
      diff  = $signed({1'b0, s}) - $signed({1'b0, d});
      ws    = $signed({1'b0, w});
      prod  = diff * ws;
      base  = 24'(d * tlac_pkg::FullWeight);
      total = $signed({3'b000, base}) + 27'(prod);
      return total[23:0];
   endfunction

   // Exact floor of n / 65025 for n below 2**24.
   function automatic logic [7:0] scale_down(input logic [23:0] n);
      logic [48:0] p;
      p = n * tlac_pkg::Recip;
      return p[tlac_pkg::RecipShift+7:tlac_pkg::RecipShift];
   endfunction

   logic [23:0] n0_ff, n0_in;
   logic [7:0]  q0_ff, q0_in;
   logic [23:0] n1_ff, n1_in;
   logic [7:0]  q1_ff, q1_in;
   logic [23:0] n2_ff, n2_in;
   logic [7:0]  q2_ff, q2_in;

   logic [7:0]  src1_d1_ff, src1_d2_ff;
   logic [15:0] w1_d1_ff, w1_d2_ff;
   logic [7:0]  src2_d1_ff, src2_d2_ff, src2_d3_ff, src2_d4_ff;
   logic [15:0] w2_d1_ff, w2_d2_ff, w2_d3_ff, w2_d4_ff;

   always_comb begin
      n0_in = blend_numer(src[0], 8'd0, weight[0]);
      q0_in = scale_down(n0_ff);
      n1_in = blend_numer(src1_d2_ff, q0_ff, w1_d2_ff);
      q1_in = scale_down(n1_ff);
      n2_in = blend_numer(src2_d4_ff, q1_ff, w2_d4_ff);
      q2_in = scale_down(n2_ff);
   end

   always_ff @(posedge clock) begin
      n0_ff      <= n0_in;
      q0_ff      <= q0_in;
      n1_ff      <= n1_in;
      q1_ff      <= q1_in;
      n2_ff      <= n2_in;
      q2_ff      <= q2_in;
      src1_d1_ff <= src[1];
      src1_d2_ff <= src1_d1_ff;
      w1_d1_ff   <= weight[1];
      w1_d2_ff   <= w1_d1_ff;
      src2_d1_ff <= src[2];
      src2_d2_ff <= src2_d1_ff;
      src2_d3_ff <= src2_d2_ff;
      src2_d4_ff <= src2_d3_ff;
      w2_d1_ff   <= weight[2];
      w2_d2_ff   <= w2_d1_ff;
      w2_d3_ff   <= w2_d2_ff;
      w2_d4_ff   <= w2_d3_ff;
   end

   assign color = q2_ff;

   // An opaque overlay replaces the running color outright.
   a_opaque_overlay: assert property (@(posedge clock)
      (w2_d4_ff == tlac_pkg::FullWeight) |-> ##2 (q2_ff == $past(src2_d4_ff, 2)))
      else $error("opaque overlay did not replace the color");

endmodule

FILE: src/tlac_merge.sv
// ----------------------------------------------------------------------------
// tlac_merge
// Carries the valid flag and alpha sum alongside the lanes and registers the
// lane colors together with the alpha as one result item.
// ----------------------------------------------------------------------------
module tlac_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                front_valid,
   input  logic [7:0]                          front_alpha,
   input  logic [tlac_pkg::NumLanes-1:0][7:0]  lane_color,
   output logic                                rsp_valid,
   output tlac_pkg::rsp_type                   rsp_data
);

   localparam int Depth = tlac_pkg::LaneDepth;

   logic [Depth-1:0]      valid_pipe_ff;
   logic [Depth-1:0][7:0] alpha_pipe_ff;
   logic                  rsp_valid_ff;
   tlac_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.out_red   = lane_color[0];
      rsp_data_in.out_green = lane_color[1];
      rsp_data_in.out_blue  = lane_color[2];
      rsp_data_in.out_alpha = alpha_pipe_ff[Depth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_pipe_ff <= {valid_pipe_ff[Depth-2:0], front_valid};
         rsp_valid_ff  <= valid_pipe_ff[Depth-1];
      end
      alpha_pipe_ff <= {alpha_pipe_ff[Depth-2:0], front_alpha};
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_valid_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(front_valid, Depth + 1))
      else $error("result strobe without a matching item");

   a_alpha_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.out_alpha == $past(front_alpha, Depth + 1)))
      else $error("alpha sum is out of step with the lanes");

endmodule

FILE: src/three_layer_alpha_compositor_top.sv
// ----------------------------------------------------------------------------
// three_layer_alpha_compositor_top
// Composites one pixel's base, mask and overlay RGBA bytes over black.
//
// An item is taken at a rising edge where start is high and busy is low;
// busy is high only for the cycle after a reset cycle, so one item can be
// given in every clock. The item travels in req_data.
// Each color channel has its own lane of six stages: per layer, one stage
// forms the blend numerator and one scales it by the exact reciprocal of
// 65025. A front stage before the lanes forms the weights and the saturated
// alpha sum, and a merge register after them joins the lanes into a result.
// A result appears on rsp_data with rsp_valid high for exactly one cycle, in
// item order; the throughput is one item per clock. The receiver cannot stall
// the block.
// The csr_ port writes the mask opacity (index 0) and the base, mask and
// overlay visibility bits (indexes 1 to 3) at any edge with csr_we high.
// Reset empties the pipeline and sets opacity to 255 and all layers visible.
// ----------------------------------------------------------------------------
module three_layer_alpha_compositor_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tlac_pkg::req_type  req_data,
   output logic               rsp_valid,
   output tlac_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   tlac_pkg::front_type                      front;
   logic [tlac_pkg::NumLanes-1:0][7:0]       lane_color;

   tlac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .front     (front)
   );

   for (genvar g = 0; g < tlac_pkg::NumLanes; g++) begin : g_lane
      tlac_lane u_lane (
         .clock  (clock),
         .src    (front.src[g]),
         .weight (front.weight),
         .color  (lane_color[g])
      );
   end

   tlac_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .front_valid (front.valid),
      .front_alpha (front.alpha),
      .lane_color  (lane_color),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: dv/three_layer_alpha_compositor_checker.sv
// ----------------------------------------------------------------------------
// three_layer_alpha_compositor_checker
// Watches the request, result and register ports of the compositor, works out
// the composited pixel for every accepted item from its own copy of the layer
// settings, and compares each result against the oldest outstanding pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_layer_alpha_compositor_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  tlac_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  tlac_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                pixels_pending
);

   localparam int Slots = 16;

   logic [7:0]        mask_opacity = 8'd255;
   logic              base_on      = 1'b1;
   logic              mask_on      = 1'b1;
   logic              overlay_on   = 1'b1;
   tlac_pkg::rsp_type expected_pixels [Slots];
   logic [3:0]        head_ptr = 4'd0;
   logic [3:0]        tail_ptr = 4'd0;
   int                held     = 0;

   function automatic int unsigned blend_lane(input int unsigned src, input int unsigned dst,
                                              input int unsigned weight);
      return (src * weight + dst * (32'd65025 - weight)) / 32'd65025;
   endfunction

   function automatic tlac_pkg::rsp_type composite_pixel(input tlac_pkg::req_type px);
      logic [7:0]        rgb [3][3];
      logic [7:0]        alpha [3];
      logic              shown [3];
      int unsigned       color [3];
      int unsigned       weight;
      int unsigned       alpha_sum;
      tlac_pkg::rsp_type pixel;
      rgb[0]    = '{px.base_red, px.base_green, px.base_blue};
      rgb[1]    = '{px.mask_red, px.mask_green, px.mask_blue};
      rgb[2]    = '{px.overlay_red, px.overlay_green, px.overlay_blue};
      alpha     = '{px.base_alpha, px.mask_alpha, px.overlay_alpha};
      shown     = '{base_on, mask_on, overlay_on};
      color     = '{0, 0, 0};
      alpha_sum = 0;
      for (int layer = 0; layer < 3; layer++) begin
         if (shown[layer]) begin
            weight = 32'(alpha[layer]) * ((layer == 1) ? 32'(mask_opacity) : 32'd255);
            for (int lane = 0; lane < 3; lane++) begin
               color[lane] = blend_lane(32'(rgb[layer][lane]), color[lane], weight);
            end
            alpha_sum = alpha_sum + 32'(alpha[layer]);
            if (alpha_sum > 255) begin
               alpha_sum = 255;
            end
         end
      end
      pixel.out_red   = color[0][7:0];
      pixel.out_green = color[1][7:0];
      pixel.out_blue  = color[2][7:0];
      pixel.out_alpha = alpha_sum[7:0];
      return pixel;
   endfunction

   always @(posedge clock) begin
      tlac_pkg::rsp_type want;
      if (reset) begin
         head_ptr     = 4'd0;
         tail_ptr     = 4'd0;
         held         = 0;
         fail_count   = 0;
         mask_opacity = 8'd255;
         base_on      = 1'b1;
         mask_on      = 1'b1;
         overlay_on   = 1'b1;
      end else begin
         if (rsp_valid) begin
            if (held == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result with no item outstanding: r=%0d g=%0d b=%0d a=%0d",
                           $realtime, rsp_data.out_red, rsp_data.out_green,
                           rsp_data.out_blue, rsp_data.out_alpha);
               end
            end else begin
               want     = expected_pixels[head_ptr];
               head_ptr = head_ptr + 4'd1;
               held     = held - 1;
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green ||
                   rsp_data.out_blue !== want.out_blue ||
                   rsp_data.out_alpha !== want.out_alpha) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
                              $realtime, want.out_red, want.out_green, want.out_blue,
                              want.out_alpha);
                     $display("   got r=%0d g=%0d b=%0d a=%0d",
                              rsp_data.out_red, rsp_data.out_green,
                              rsp_data.out_blue, rsp_data.out_alpha);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (held == Slots) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: too many items outstanding", $realtime);
               end
            end else begin
               expected_pixels[tail_ptr] = composite_pixel(req_data);
               tail_ptr = tail_ptr + 4'd1;
               held     = held + 1;
            end
         end
         if (csr_we) begin
            case (tlac_pkg::csr_index_type'(csr_index))
               tlac_pkg::CSR_MASK_OPACITY: begin
                  mask_opacity = csr_wdata;
               end
               tlac_pkg::CSR_BASE_VISIBLE: begin
                  base_on = csr_wdata[0];
               end
               tlac_pkg::CSR_MASK_VISIBLE: begin
                  mask_on = csr_wdata[0];
               end
               tlac_pkg::CSR_OVERLAY_VISIBLE: begin
                  overlay_on = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
      pixels_pending = held;
   end

endmodule

FILE: dv/three_layer_alpha_compositor_top_tb.sv
// ----------------------------------------------------------------------------
// three_layer_alpha_compositor_top_tb
// Drives pixel items into the three-layer alpha compositor under a series of
// opacity and layer visibility settings: directed corner pixels first, then
// random pixels with biased alphas and sender gaps of varying density. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_layer_alpha_compositor_top_tb;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   tlac_pkg::req_type req_data;
   logic              rsp_valid;
   tlac_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [7:0]        csr_wdata;
   int                fail_count;
   int                pixels_pending;

   three_layer_alpha_compositor_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   three_layer_alpha_compositor_checker pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Each layer is given as one RGBA word, red in the top byte.
   function automatic tlac_pkg::req_type make_pixel(input logic [31:0] base,
                                                    input logic [31:0] mask,
                                                    input logic [31:0] overlay);
      return tlac_pkg::req_type'({base, mask, overlay});
   endfunction

   function automatic logic [7:0] biased_byte();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic tlac_pkg::req_type random_pixel();
      logic [31:0] layers [3];
      for (int layer = 0; layer < 3; layer++) begin
         layers[layer] = ($urandom_range(0, 3) == 0) ?
                         {biased_byte(), biased_byte(), biased_byte(), biased_byte()} :
                         {8'($urandom), 8'($urandom), 8'($urandom), biased_byte()};
      end
      return make_pixel(layers[0], layers[1], layers[2]);
   endfunction

   // Called just after a falling edge; returns just after the falling edge
   // that follows the rising edge at which the item was taken.
   task automatic send_pixel(input tlac_pkg::req_type px, input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pixels_pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_layers(input logic [7:0] opacity, input logic base_vis,
                             input logic mask_vis, input logic overlay_vis);
      csr_we    <= 1'b1;
      csr_index <= tlac_pkg::CSR_MASK_OPACITY;
      csr_wdata <= opacity;
      @(negedge clock);
      csr_index <= tlac_pkg::CSR_BASE_VISIBLE;
      csr_wdata <= {7'($urandom), base_vis};
      @(negedge clock);
      csr_index <= tlac_pkg::CSR_MASK_VISIBLE;
      csr_wdata <= {7'($urandom), mask_vis};
      @(negedge clock);
      csr_index <= tlac_pkg::CSR_OVERLAY_VISIBLE;
      csr_wdata <= {7'($urandom), overlay_vis};
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(input logic [7:0] opacity, input logic [2:0] visible,
                             input int idle_pct, input int count);
      set_layers(opacity, visible[2], visible[1], visible[0]);
      for (int n = 0; n < count; n++) begin
         send_pixel(random_pixel(), ($urandom_range(0, 3) == 0) ? 0 : idle_pct);
      end
      settle();
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = tlac_pkg::CSR_MASK_OPACITY;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_pixel(make_pixel(32'h00000000, 32'h00000000, 32'h00000000), 0);
      send_pixel(make_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0);
      send_pixel(make_pixel(32'hFF0000FF, 32'h00FF0000, 32'h0000FF00), 0);
      send_pixel(make_pixel(32'hFF0000FF, 32'h00FF00FF, 32'h0000FF00), 0);
      send_pixel(make_pixel(32'hFF0000FF, 32'h00FF00FF, 32'h0000FFFF), 0);
      send_pixel(make_pixel(32'hFFFFFF80, 32'h00000080, 32'hFFFFFF80), 0);
      send_pixel(make_pixel(32'h102030C8, 32'h405060C8, 32'h708090C8), 0);
      send_pixel(make_pixel(32'hAABBCC64, 32'h11223364, 32'hDDEEFF37), 0);
      send_pixel(make_pixel(32'hFFFFFF01, 32'hFFFFFF01, 32'hFFFFFF01), 0);
      send_pixel(make_pixel(32'h000000FE, 32'hFFFFFFFE, 32'h000000FE), 0);
      send_pixel(make_pixel(32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFF00), 0);
      send_pixel(make_pixel(32'h55AA5540, 32'hAA55AA20, 32'h0F0F0F10), 0);
      settle();
      set_layers(8'd0, 1'b1, 1'b1, 1'b1);
      send_pixel(make_pixel(32'h204060FF, 32'hFFFFFFFF, 32'h00000000), 0);
      send_pixel(make_pixel(32'h20406080, 32'h000000C0, 32'hFFFFFF10), 0);
      settle();
      set_layers(8'd1, 1'b1, 1'b1, 1'b1);
      send_pixel(make_pixel(32'h000000FF, 32'hFFFFFFFF, 32'h00000000), 0);
      settle();
      set_layers(8'd255, 1'b0, 1'b0, 1'b0);
      send_pixel(make_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0);
      send_pixel(make_pixel(32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C), 0);
      settle();

      run_random(8'd255, 3'b111, 0, 112);
      run_random(8'd0, 3'b111, 50, 112);
      run_random(8'd1, 3'b111, 15, 112);
      run_random(8'd128, 3'b011, 0, 112);
      run_random(8'd200, 3'b101, 50, 112);
      run_random(8'd90, 3'b110, 15, 112);
      run_random(8'd255, 3'b000, 0, 30);
      run_random(8'($urandom), 3'($urandom), 50, 112);
      run_random(8'($urandom), 3'($urandom), 15, 112);
      run_random(8'($urandom), 3'b111, 0, 112);

      if (fail_count == 0 && pixels_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
